// ----- rtl/segmented_prime_count_unit_macros.svh -----
// Assertion macros shared by the checkers of the segmented prime count unit.
// Plain text macros; no dependencies.
`ifndef SEGMENTED_PRIME_COUNT_UNIT_MACROS_SVH
`define SEGMENTED_PRIME_COUNT_UNIT_MACROS_SVH

// Same-cycle implication.
`define SPC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SPC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/spc_pkg.sv -----
// Shared constants and derived widths for the segmented prime count unit.
// No dependencies.
package spc_pkg;

   localparam int unsigned SEGMENT_SPAN = 131072;
   localparam int unsigned BASE_LIMIT   = 65536;

   localparam int unsigned RANGE_W = 31;
   localparam int unsigned COUNT_W = 18;

   // segment store keeps odd offsets only
   localparam int unsigned SEG_DEPTH  = (SEGMENT_SPAN + 1) / 2;
   localparam int unsigned SEG_IDX_W  = $clog2(SEG_DEPTH);
   localparam int unsigned SPAN_W     = $clog2(SEGMENT_SPAN);

   // base table keeps odd values only, one composite bit each
   localparam int unsigned BASE_DEPTH = BASE_LIMIT / 2;
   localparam int unsigned BASE_IDX_W = $clog2(BASE_DEPTH);

   localparam int unsigned P_W   = $clog2(BASE_LIMIT) + 1;
   localparam int unsigned PSQ_W = 2 * P_W;
   localparam int unsigned OFF_W = $clog2(SEGMENT_SPAN + 2 * BASE_LIMIT);

   // remainder unit, radix 2 with two steps per cycle
   localparam int unsigned DIV_BITS   = 2;
   localparam int unsigned DIV_STEPS  = (RANGE_W + DIV_BITS - 1) / DIV_BITS;
   localparam int unsigned DIV_W      = DIV_STEPS * DIV_BITS;
   localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam int unsigned INIT_LEN = (SEG_DEPTH > BASE_DEPTH) ? SEG_DEPTH : BASE_DEPTH;
   localparam int unsigned INIT_W   = $clog2(INIT_LEN);

endpackage

// ----- rtl/spc_if.sv -----
// Valid/ready channel interfaces for query and response transactions.
// Depends on spc_pkg for field widths.
interface spc_req_if;
   logic                          valid;
   logic                          ready;
   logic [spc_pkg::RANGE_W-1:0]   range_low;
   logic [spc_pkg::RANGE_W-1:0]   range_high;

   modport source (output valid, output range_low, output range_high, input ready);
   modport sink   (input valid, input range_low, input range_high, output ready);
endinterface

interface spc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [spc_pkg::COUNT_W-1:0]   prime_count;
   logic                          range_error;

   modport source (output valid, output prime_count, output range_error, input ready);
   modport sink   (input valid, input prime_count, input range_error, output ready);
endinterface

// ----- rtl/segmented_prime_count_unit.sv -----
// Segmented prime counter: one query in, one count out, over two bit memories.
// Depends on spc_pkg and the channel interfaces in spc_if.sv.
//
// Counts the primes in the closed interval [range_low, range_high]; spans of more
// than SEGMENT_SPAN odd-adjusted values return range_error with a zero count. After
// reset the block clears both memories over INIT_LEN (65536) addresses and then
// sieves its base table of odd composites below BASE_LIMIT before it raises ready.
// One query is worked at a time. A query tests each odd candidate p with
// p*p <= range_high in the base table, takes lo mod p for each base prime in the
// two-bit-per-cycle remainder unit, marks each odd multiple in range, then runs the
// count scan, which also clears the segment for the next query. The single write
// port of the segment memory, one mark or one scan read per cycle, bounds the run
// time of a query.
// The response sits in an output register, so the next query is taken while it waits.
module segmented_prime_count_unit (
   input  logic      clock,
   input  logic      reset,
   spc_req_if.sink   req_chan,
   spc_rsp_if.source rsp_chan
);

   typedef enum logic [3:0] {
      S_INIT, S_BTEST, S_BFLAG, S_BMARK,
      S_IDLE, S_SETUP, S_PTEST, S_PFLAG, S_DIV, S_PSTART, S_MARK,
      S_SCAN, S_DRAIN, S_RESULT
   } state_type;

   state_type                        state_ff, state_in;
   logic [spc_pkg::INIT_W-1:0]       init_cnt_ff, init_cnt_in;
   logic [spc_pkg::RANGE_W-1:0]      lo_ff, lo_in, hi_ff, hi_in;
   logic [spc_pkg::SPAN_W-1:0]       span_ff, span_in;
   logic [spc_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic                             err_ff, err_in;
   logic [spc_pkg::P_W-1:0]          p_ff, p_in;
   logic [spc_pkg::PSQ_W-1:0]        psq_ff, psq_in;
   logic [spc_pkg::OFF_W-1:0]        off_ff, off_in;
   logic                             first_ff, first_in;
   logic [spc_pkg::DIV_W-1:0]        div_sh_ff, div_sh_in;
   logic [spc_pkg::P_W-1:0]          rem_ff, rem_in;
   logic [spc_pkg::DIV_CNT_W-1:0]    div_cnt_ff, div_cnt_in;
   logic [spc_pkg::SEG_IDX_W-1:0]    scan_idx_ff, scan_idx_in;
   logic                             seg_rd_vld_ff, seg_rd_vld_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [spc_pkg::COUNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic                             rsp_err_ff, rsp_err_in;

   // composite bit per odd value below BASE_LIMIT
   logic                             base_mem [spc_pkg::BASE_DEPTH];
   logic                             base_rd_ff;
   logic                             base_we, base_wd;
   logic [spc_pkg::BASE_IDX_W-1:0]   base_wa, base_ra;

   // composite mark per odd offset of the current segment
   logic                             seg_mem [spc_pkg::SEG_DEPTH];
   logic                             seg_rd_ff;
   logic                             seg_we, seg_wd;
   logic [spc_pkg::SEG_IDX_W-1:0]    seg_wa, seg_ra;

   logic [spc_pkg::RANGE_W-1:0]      lo_adj, span_full;
   logic                             lo_two;
   logic [spc_pkg::P_W-1:0]          p_next;
   logic [spc_pkg::PSQ_W-1:0]        psq_next;
   logic [spc_pkg::OFF_W-1:0]        off_step, off_start, start_base;
   logic                             mark_in_range, self_hit;
   logic [spc_pkg::SEG_IDX_W-1:0]    scan_last;
   logic [spc_pkg::P_W-1:0]          rem_nx;
   logic [spc_pkg::DIV_W-1:0]        sh_nx;

   assign lo_two    = (lo_ff <= spc_pkg::RANGE_W'(2));
   assign lo_adj    = (lo_ff < spc_pkg::RANGE_W'(3)) ? spc_pkg::RANGE_W'(3)
                                                      : (lo_ff | spc_pkg::RANGE_W'(1));
   assign span_full = hi_ff - lo_adj;

   assign p_next    = p_ff + spc_pkg::P_W'(2);
   assign psq_next  = psq_ff + spc_pkg::PSQ_W'({p_ff, 2'b00}) + spc_pkg::PSQ_W'(4);
   assign off_step  = spc_pkg::OFF_W'({p_ff, 1'b0});

   // first odd multiple at or above lo, as an offset from lo
   assign start_base = rem_ff[0] ? spc_pkg::OFF_W'(p_ff) : off_step;
   assign off_start  = (rem_ff == '0) ? '0 : start_base - spc_pkg::OFF_W'(rem_ff);

   assign mark_in_range = (off_ff <= spc_pkg::OFF_W'(span_ff));
   assign self_hit      = (lo_ff <= spc_pkg::RANGE_W'(p_ff));
   assign scan_last     = spc_pkg::SEG_IDX_W'(span_ff >> 1);

   assign base_ra = p_ff[spc_pkg::BASE_IDX_W:1];
   assign seg_ra  = scan_idx_ff;

   always_comb begin : div_step
      logic [spc_pkg::P_W-1:0] rem_t;
      rem_nx = rem_ff;
      sh_nx  = div_sh_ff;
      for (int k = 0; k < spc_pkg::DIV_BITS; k++) begin
         rem_t = {rem_nx[spc_pkg::P_W-2:0], sh_nx[spc_pkg::DIV_W-1]};
         sh_nx = {sh_nx[spc_pkg::DIV_W-2:0], 1'b0};
         if (rem_t >= p_ff) begin
            rem_nx = rem_t - p_ff;
         end else begin
            rem_nx = rem_t;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      init_cnt_in   = init_cnt_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      span_in       = span_ff;
      count_in      = count_ff;
      err_in        = err_ff;
      p_in          = p_ff;
      psq_in        = psq_ff;
      off_in        = off_ff;
      first_in      = first_ff;
      div_sh_in     = div_sh_ff;
      rem_in        = rem_ff;
      div_cnt_in    = div_cnt_ff;
      scan_idx_in   = scan_idx_ff;
      seg_rd_vld_in = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_count_in  = rsp_count_ff;
      rsp_err_in    = rsp_err_ff;
      base_we       = 1'b0;
      base_wa       = off_ff[spc_pkg::BASE_IDX_W:1];
      base_wd       = 1'b1;
      seg_we        = 1'b0;
      seg_wa        = off_ff[spc_pkg::SEG_IDX_W:1];
      seg_wd        = 1'b1;

      if (seg_rd_vld_ff && !seg_rd_ff) begin
         count_in = count_ff + spc_pkg::COUNT_W'(1);
      end

      unique case (state_ff)
         S_INIT: begin
            seg_we  = {1'b0, init_cnt_ff} < (spc_pkg::INIT_W + 1)'(spc_pkg::SEG_DEPTH);
            seg_wa  = init_cnt_ff[spc_pkg::SEG_IDX_W-1:0];
            seg_wd  = 1'b0;
            base_we = {1'b0, init_cnt_ff} < (spc_pkg::INIT_W + 1)'(spc_pkg::BASE_DEPTH);
            base_wa = init_cnt_ff[spc_pkg::BASE_IDX_W-1:0];
            base_wd = 1'b0;
            if (init_cnt_ff == spc_pkg::INIT_W'(spc_pkg::INIT_LEN - 1)) begin
               p_in     = spc_pkg::P_W'(3);
               psq_in   = spc_pkg::PSQ_W'(9);
               state_in = S_BTEST;
            end else begin
               init_cnt_in = init_cnt_ff + spc_pkg::INIT_W'(1);
            end
         end
         S_BTEST: begin
            if (psq_ff >= spc_pkg::PSQ_W'(spc_pkg::BASE_LIMIT)) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_BFLAG;
            end
         end
         S_BFLAG: begin
            if (base_rd_ff) begin
               p_in     = p_next;
               psq_in   = psq_next;
               state_in = S_BTEST;
            end else begin
               off_in   = spc_pkg::OFF_W'(psq_ff);
               state_in = S_BMARK;
            end
         end
         S_BMARK: begin
            if (off_ff < spc_pkg::OFF_W'(spc_pkg::BASE_LIMIT)) begin
               base_we = 1'b1;
               off_in  = off_ff + off_step;
            end else begin
               p_in     = p_next;
               psq_in   = psq_next;
               state_in = S_BTEST;
            end
         end
         S_IDLE: begin
            if (req_chan.valid) begin
               lo_in    = req_chan.range_low;
               hi_in    = req_chan.range_high;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            err_in = 1'b0;
            priority if (hi_ff < spc_pkg::RANGE_W'(2)) begin
               count_in = '0;
               state_in = S_RESULT;
            end else if (hi_ff < lo_adj) begin
               count_in = spc_pkg::COUNT_W'(lo_two);
               state_in = S_RESULT;
            end else if (span_full >= spc_pkg::RANGE_W'(spc_pkg::SEGMENT_SPAN)) begin
               count_in = '0;
               err_in   = 1'b1;
               state_in = S_RESULT;
            end else begin
               count_in = spc_pkg::COUNT_W'(lo_two);
               lo_in    = lo_adj;
               span_in  = span_full[spc_pkg::SPAN_W-1:0];
               p_in     = spc_pkg::P_W'(3);
               psq_in   = spc_pkg::PSQ_W'(9);
               state_in = S_PTEST;
            end
         end
         S_PTEST: begin
            if (p_ff >= spc_pkg::P_W'(spc_pkg::BASE_LIMIT) ||
                psq_ff > spc_pkg::PSQ_W'(hi_ff)) begin
               scan_idx_in = '0;
               state_in    = S_SCAN;
            end else begin
               state_in = S_PFLAG;
            end
         end
         S_PFLAG: begin
            if (base_rd_ff) begin
               p_in     = p_next;
               psq_in   = psq_next;
               state_in = S_PTEST;
            end else begin
               div_sh_in  = spc_pkg::DIV_W'(lo_ff);
               rem_in     = '0;
               div_cnt_in = '0;
               state_in   = S_DIV;
            end
         end
         S_DIV: begin
            rem_in    = rem_nx;
            div_sh_in = sh_nx;
            if (div_cnt_ff == spc_pkg::DIV_CNT_W'(spc_pkg::DIV_STEPS - 1)) begin
               state_in = S_PSTART;
            end else begin
               div_cnt_in = div_cnt_ff + spc_pkg::DIV_CNT_W'(1);
            end
         end
         S_PSTART: begin
            off_in   = off_start;
            first_in = 1'b1;
            state_in = S_MARK;
         end
         S_MARK: begin
            if (mark_in_range) begin
               // the prime itself is never marked
               seg_we   = !(first_ff && self_hit);
               off_in   = off_ff + off_step;
               first_in = 1'b0;
            end else begin
               p_in     = p_next;
               psq_in   = psq_next;
               state_in = S_PTEST;
            end
         end
         S_SCAN: begin
            seg_we        = 1'b1;
            seg_wa        = scan_idx_ff;
            seg_wd        = 1'b0;
            seg_rd_vld_in = 1'b1;
            if (scan_idx_ff == scan_last) begin
               state_in = S_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + spc_pkg::SEG_IDX_W'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
               rsp_err_in   = err_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         init_cnt_ff   <= '0;
         seg_rd_vld_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         init_cnt_ff   <= init_cnt_in;
         seg_rd_vld_ff <= seg_rd_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      span_ff      <= span_in;
      count_ff     <= count_in;
      err_ff       <= err_in;
      p_ff         <= p_in;
      psq_ff       <= psq_in;
      off_ff       <= off_in;
      first_ff     <= first_in;
      div_sh_ff    <= div_sh_in;
      rem_ff       <= rem_in;
      div_cnt_ff   <= div_cnt_in;
      scan_idx_ff  <= scan_idx_in;
      rsp_count_ff <= rsp_count_in;
      rsp_err_ff   <= rsp_err_in;
   end

   always_ff @(posedge clock) begin
      if (base_we) begin
         base_mem[base_wa] <= base_wd;
      end
      base_rd_ff <= base_mem[base_ra];
   end

   // read returns the old bit when the scan clears the same entry
   always_ff @(posedge clock) begin
      if (seg_we) begin
         seg_mem[seg_wa] <= seg_wd;
      end
      seg_rd_ff <= seg_mem[seg_ra];
   end

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.prime_count = rsp_count_ff;
   assign rsp_chan.range_error = rsp_err_ff;

endmodule

// ----- rtl/spc_checker.sv -----
// Port-level assertions for segmented_prime_count_unit, bound to the top level.
// Depends on spc_pkg and segmented_prime_count_unit_macros.svh.
`include "segmented_prime_count_unit_macros.svh"

module spc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [spc_pkg::COUNT_W-1:0]   rsp_prime_count,
   input logic                          rsp_range_error
);

   `SPC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_prime_count) && $stable(rsp_range_error), "response transaction changed while stalled")
   `SPC_ASSERT_NXT(a_one_query, clock, reset, req_valid && req_ready, !req_ready, "query taken while another is in work")
   `SPC_ASSERT_IMP(a_err_zero, clock, reset, rsp_valid && rsp_range_error, rsp_prime_count == '0, "range error with nonzero count")
   `SPC_ASSERT_IMP(a_count_max, clock, reset, rsp_valid, rsp_prime_count <= spc_pkg::COUNT_W'(spc_pkg::SEG_DEPTH + 1), "count above segment capacity")

endmodule

bind segmented_prime_count_unit spc_checker u_spc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_prime_count (rsp_chan.prime_count),
   .rsp_range_error (rsp_chan.range_error)
);
